>>> rtl/nfsa_pkg.sv
`default_nettype none

package nfsa_pkg;

   // table geometry
   localparam int MAX_SITES    = 64;
   localparam int SITE_BITS    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
   localparam int CNT_BITS     = $clog2(MAX_SITES + 1);

   // field widths
   localparam int COORD_BITS   = 16;
   localparam int DIST_BITS    = COORD_BITS + 1;
   localparam int CAP_BITS     = 16;
   localparam int ACTIVE_BITS  = 7;
   localparam int FUNC_BITS    = 2;

   // function codes
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_PLACE = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd2;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [CAP_BITS-1:0]          limit;
      logic [CAP_BITS-1:0]          count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic [FUNC_BITS-1:0]         func;
      logic [SITE_BITS-1:0]         site_index;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic [CAP_BITS-1:0]          site_capacity;
   } req_type;

   typedef struct packed {
      logic [SITE_BITS-1:0] chosen_site;
      logic [DIST_BITS-1:0] best_distance;
      logic [CAP_BITS-1:0]  occupancy;
      logic                 no_space;
   } rsp_type;

   typedef struct packed {
      logic                 we;
      logic [SITE_BITS-1:0] waddr;
      entry_type            wdata;
      logic                 re;
      logic [SITE_BITS-1:0] raddr;
   } ram_ctl_type;

endpackage

`default_nettype wire

>>> rtl/nearest_free_slot_assigner.sv
`default_nettype none

// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------
// req      | in        | req_valid / req_ready     | func, site_index, pos_x, pos_y,
//          |           |                           | site_capacity
// rsp      | out       | rsp_valid / rsp_ready     | chosen_site, best_distance,
//          |           |                           | occupancy, no_space
// csr      | in        | csr_write_enable, no wait | active_sites
//
// one item at a time; the site table sits in one single-port-read ram
// load and unused func codes go straight to the hand-off; read waits on the table read first
// place scans the active sites (active_sites clipped to 64): one table
// read per cycle, two pipeline stages to drain, one write-back of the bumped
// count, one hand-off; no write-back when every site is full, and no scan with none active
// sync reset clears control and the per-site loaded bits, no clearing pass
// a held result in the rsp register does not block the next req item

module nearest_free_slot_assigner (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [nfsa_pkg::FUNC_BITS-1:0]      req_func,
   input  wire logic [nfsa_pkg::SITE_BITS-1:0]      req_site_index,
   input  wire logic signed [nfsa_pkg::COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [nfsa_pkg::COORD_BITS-1:0] req_pos_y,
   input  wire logic [nfsa_pkg::CAP_BITS-1:0]       req_site_capacity,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [nfsa_pkg::SITE_BITS-1:0]           rsp_chosen_site,
   output logic [nfsa_pkg::DIST_BITS-1:0]           rsp_best_distance,
   output logic [nfsa_pkg::CAP_BITS-1:0]            rsp_occupancy,
   output logic                                     rsp_no_space,

   input  wire logic                                csr_write_enable,
   input  wire logic [nfsa_pkg::ACTIVE_BITS-1:0]    csr_write_data
);

   // active_sites register
   logic [nfsa_pkg::ACTIVE_BITS-1:0] active_ff, active_in;

   // output register between the engine and the rsp channel
   logic                    rsp_valid_ff, rsp_valid_in;
   nfsa_pkg::rsp_type       rsp_ff, rsp_in;
   logic                    out_load;

   nfsa_pkg::req_type       req;
   nfsa_pkg::rsp_type       res;
   logic                    res_valid;
   nfsa_pkg::ram_ctl_type   ram_ctl;
   nfsa_pkg::entry_type     ram_rdata;

   assign req.func          = req_func;
   assign req.site_index    = req_site_index;
   assign req.pos_x         = req_pos_x;
   assign req.pos_y         = req_pos_y;
   assign req.site_capacity = req_site_capacity;

   assign active_in = csr_write_enable ? csr_write_data : active_ff;

   // engine hands over its result once the output slot is empty or draining
   assign out_load     = res_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = out_load ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chosen_site   = rsp_ff.chosen_site;
   assign rsp_best_distance = rsp_ff.best_distance;
   assign rsp_occupancy     = rsp_ff.occupancy;
   assign rsp_no_space      = rsp_ff.no_space;

   // site table: x, y, capacity and count per entry
   nfsa_ram #(
      .WIDTH (nfsa_pkg::ENTRY_BITS),
      .DEPTH (nfsa_pkg::MAX_SITES)
   ) u_table (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .re    (ram_ctl.re),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   nfsa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req          (req),
      .active_sites (active_ff),
      .res_valid    (res_valid),
      .res_taken    (out_load),
      .res          (res),
      .ram_ctl      (ram_ctl),
      .ram_rdata    (ram_rdata)
   );

endmodule

`default_nettype wire

>>> rtl/nfsa_ram.sv
`default_nettype none

module nfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic                 re,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/nfsa_ctrl.sv
`default_nettype none

module nfsa_ctrl (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire nfsa_pkg::req_type                   req,
   input  wire logic [nfsa_pkg::ACTIVE_BITS-1:0]    active_sites,
   output logic                                     res_valid,
   input  wire logic                                res_taken,
   output nfsa_pkg::rsp_type                        res,
   output nfsa_pkg::ram_ctl_type                    ram_ctl,
   input  wire nfsa_pkg::entry_type                 ram_rdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [nfsa_pkg::SITE_BITS-1:0]  idx_ff, idx_in;
   logic signed [nfsa_pkg::COORD_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [nfsa_pkg::CNT_BITS-1:0]   n_ff, n_in, n_cur;
   logic [nfsa_pkg::CNT_BITS-1:0]   addr_ff, addr_in;
   logic                            issuing;

   // read pipeline: issue -> ram data -> candidate distance -> best
   logic                            issue_ff, issue_in;
   logic [nfsa_pkg::SITE_BITS-1:0]  issue_idx_ff, issue_idx_in;
   logic                            cand_vld_ff, cand_vld_in;
   logic                            cand_free_ff, cand_free_in;
   logic [nfsa_pkg::DIST_BITS-1:0]  cand_dist_ff, cand_dist_in;
   nfsa_pkg::entry_type             cand_entry_ff, cand_entry_in;
   logic [nfsa_pkg::SITE_BITS-1:0]  cand_idx_ff, cand_idx_in;

   logic                            found_ff, found_in;
   logic [nfsa_pkg::DIST_BITS-1:0]  best_dist_ff, best_dist_in;
   nfsa_pkg::entry_type             best_entry_ff, best_entry_in;
   logic [nfsa_pkg::SITE_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [nfsa_pkg::CAP_BITS-1:0]   best_next_cnt;

   logic [nfsa_pkg::MAX_SITES-1:0]  vld_ff, vld_in;
   nfsa_pkg::rsp_type               res_ff, res_in;

   logic signed [nfsa_pkg::DIST_BITS-1:0] dx, dy;
   logic [nfsa_pkg::COORD_BITS-1:0] adx, ady;
   logic                            better;
   logic                            req_in_range, idx_in_range;

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // active count clipped to table size
   always_comb begin
      if (nfsa_pkg::CNT_BITS'(nfsa_pkg::MAX_SITES) < active_sites) begin
         n_cur = nfsa_pkg::CNT_BITS'(nfsa_pkg::MAX_SITES);
      end else begin
         n_cur = nfsa_pkg::CNT_BITS'(active_sites);
      end
   end

   assign req_in_range = nfsa_pkg::CNT_BITS'(req.site_index)
                         < nfsa_pkg::CNT_BITS'(nfsa_pkg::MAX_SITES);
   assign idx_in_range = nfsa_pkg::CNT_BITS'(idx_ff)
                         < nfsa_pkg::CNT_BITS'(nfsa_pkg::MAX_SITES);
   assign issuing       = (state_ff == ST_SCAN) && (addr_ff < n_ff);
   assign best_next_cnt = best_entry_ff.count + 1'b1;

   // candidate stage: distance and free check on returned entry
   always_comb begin
      dx = {rx_ff[nfsa_pkg::COORD_BITS-1], rx_ff}
           - {ram_rdata.x[nfsa_pkg::COORD_BITS-1], ram_rdata.x};
      dy = {ry_ff[nfsa_pkg::COORD_BITS-1], ry_ff}
           - {ram_rdata.y[nfsa_pkg::COORD_BITS-1], ram_rdata.y};
      adx = dx[nfsa_pkg::DIST_BITS-1] ? nfsa_pkg::COORD_BITS'(-dx)
                                      : nfsa_pkg::COORD_BITS'(dx);
      ady = dy[nfsa_pkg::DIST_BITS-1] ? nfsa_pkg::COORD_BITS'(-dy)
                                      : nfsa_pkg::COORD_BITS'(dy);
      cand_vld_in   = issue_ff;
      cand_free_in  = (ram_rdata.count != ram_rdata.limit);
      cand_dist_in  = {1'b0, adx} + {1'b0, ady};
      cand_entry_in = ram_rdata;
      cand_idx_in   = issue_idx_ff;
   end

   // best stage: distance, then x, then y; lower index wins by scan order
   always_comb begin
      better = !found_ff || (cand_dist_ff < best_dist_ff)
               || ((cand_dist_ff == best_dist_ff)
                   && (($signed(cand_entry_ff.x) < $signed(best_entry_ff.x))
                       || ((cand_entry_ff.x == best_entry_ff.x)
                           && ($signed(cand_entry_ff.y) < $signed(best_entry_ff.y)))));
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rx_in         = rx_ff;
      ry_in         = ry_ff;
      n_in          = n_ff;
      addr_in       = addr_ff;
      issue_in      = issuing;
      issue_idx_in  = addr_ff[nfsa_pkg::SITE_BITS-1:0];
      found_in      = found_ff;
      best_dist_in  = best_dist_ff;
      best_entry_in = best_entry_ff;
      best_idx_in   = best_idx_ff;
      vld_in        = vld_ff;
      res_in        = res_ff;

      ram_ctl              = '0;
      ram_ctl.waddr        = best_idx_ff;
      ram_ctl.wdata        = best_entry_ff;
      ram_ctl.wdata.count  = best_next_cnt;
      ram_ctl.raddr        = addr_ff[nfsa_pkg::SITE_BITS-1:0];

      if (cand_vld_ff && cand_free_ff && better) begin
         found_in      = 1'b1;
         best_dist_in  = cand_dist_ff;
         best_entry_in = cand_entry_ff;
         best_idx_in   = cand_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               idx_in = req.site_index;
               rx_in  = req.pos_x;
               ry_in  = req.pos_y;
               res_in = '0;
               res_in.chosen_site = req.site_index;
               unique case (req.func)
                  nfsa_pkg::FUNC_LOAD: begin
                     if (req_in_range) begin
                        ram_ctl.we          = 1'b1;
                        ram_ctl.waddr       = req.site_index;
                        ram_ctl.wdata.x     = req.pos_x;
                        ram_ctl.wdata.y     = req.pos_y;
                        ram_ctl.wdata.limit = req.site_capacity;
                        ram_ctl.wdata.count = '0;
                        vld_in[req.site_index] = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  nfsa_pkg::FUNC_PLACE: begin
                     n_in     = n_cur;
                     addr_in  = '0;
                     found_in = 1'b0;
                     if (n_cur == '0) begin
                        res_in          = '0;
                        res_in.no_space = 1'b1;
                        state_in        = ST_DONE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  nfsa_pkg::FUNC_READ: begin
                     ram_ctl.re    = 1'b1;
                     ram_ctl.raddr = req.site_index;
                     state_in      = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               ram_ctl.re = 1'b1;
               addr_in    = addr_ff + 1'b1;
            end else if (!issue_ff && !cand_vld_ff) begin
               if (found_ff) begin
                  state_in = ST_WRITE;
               end else begin
                  res_in          = '0;
                  res_in.no_space = 1'b1;
                  state_in        = ST_DONE;
               end
            end
         end
         ST_READ: begin
            // entries never loaded read as zero count
            if (idx_in_range && vld_ff[idx_ff]) begin
               res_in.occupancy = ram_rdata.count;
            end else begin
               res_in.occupancy = '0;
            end
            state_in = ST_DONE;
         end
         ST_WRITE: begin
            ram_ctl.we           = 1'b1;
            res_in.chosen_site   = best_idx_ff;
            res_in.best_distance = best_dist_ff;
            res_in.occupancy     = best_next_cnt;
            res_in.no_space      = 1'b0;
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issue_ff    <= 1'b0;
         cand_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         vld_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         issue_ff    <= issue_in;
         cand_vld_ff <= cand_vld_in;
         found_ff    <= found_in;
         vld_ff      <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rx_ff         <= rx_in;
      ry_ff         <= ry_in;
      n_ff          <= n_in;
      addr_ff       <= addr_in;
      issue_idx_ff  <= issue_idx_in;
      cand_free_ff  <= cand_free_in;
      cand_dist_ff  <= cand_dist_in;
      cand_entry_ff <= cand_entry_in;
      cand_idx_ff   <= cand_idx_in;
      best_dist_ff  <= best_dist_in;
      best_entry_ff <= best_entry_in;
      best_idx_ff   <= best_idx_in;
      res_ff        <= res_in;
   end

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_ctl.we && ram_ctl.re))
      else $error("table read and write in the same cycle");

   a_write_needs_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> found_ff)
      else $error("write-back without a chosen site");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (addr_ff <= n_ff))
      else $error("scan address ran past active sites");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && found_ff)
         |-> (nfsa_pkg::CNT_BITS'(best_idx_ff) < n_ff))
      else $error("chosen site outside active range");

   a_full_result_clean: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.no_space)
         |-> (res.chosen_site == '0 && res.best_distance == '0
              && res.occupancy == '0))
      else $error("no_space result carries data");

endmodule

`default_nettype wire
